[rtl/qlf_pkg.sv]
`default_nettype none

package qlf_pkg;

   // frame bytes
   localparam logic [7:0] FRAME_SYNC = 8'h55;
   localparam logic [7:0] FRAME_CMD  = 8'h12;
   localparam logic [7:0] FRAME_CR   = 8'h0D;
   localparam logic [7:0] FRAME_LF   = 8'h0A;
   localparam logic [7:0] LEVEL_BIAS = 8'd2;

   localparam int unsigned FRAME_LEN = 5;
   localparam logic [2:0]  LAST_IDX  = 3'(FRAME_LEN - 1);

   // reset values of state and registers
   localparam logic [3:0] LEVEL_RESET = 4'd9;
   localparam logic [2:0] SPD_RESET   = 3'd2;
   localparam logic [3:0] MAX_RESET   = 4'd9;

   // register indexes (paddr bit 2)
   localparam logic CSR_SPD = 1'b0;
   localparam logic CSR_MAX = 1'b1;

   typedef struct packed {
      logic pin_a;
      logic pin_b;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [2:0] steps_per_detent;
      logic [3:0] max_level;
   } cfg_type;

   // quadrature step for {prev_ab, cur_ab}
   function automatic logic signed [1:0] step_of(input logic [3:0] idx);
      logic signed [1:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default:                 s = 2'sd0;
      endcase
      return s;
   endfunction

   // whole detents in a step magnitude (magnitude at most 8, size 1 to 7)
   function automatic logic [3:0] detent_div(input logic [3:0] mag, input logic [2:0] spd);
      logic [3:0] q;
      logic [6:0] prod;
      q = 4'd0;
      for (int i = 1; i <= 8; i++) begin
         prod = 7'(i) * {4'b0, spd};
         if (prod <= {3'b0, mag}) begin
            q = 4'(i);
         end
      end
      return q;
   endfunction

   // one byte of the command frame
   function automatic logic [7:0] frame_byte_of(input logic [3:0] lvl, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = FRAME_SYNC;
         3'd1:    b = FRAME_CMD;
         3'd2:    b = {4'b0, lvl} + LEVEL_BIAS;
         3'd3:    b = FRAME_CR;
         3'd4:    b = FRAME_LF;
         default: b = FRAME_LF;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[rtl/qlf_front.sv]
`default_nettype none

module qlf_front
   import qlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire req_type    sample,
   output logic            lvl_push,
   output logic [3:0]      lvl_value
);

   logic [3:0]        ab_ff, ab_in;
   logic signed [3:0] pend_ff, pend_in;
   logic [3:0]        level_ff, level_in;

   logic              [3:0] idx;
   logic signed       [1:0] step;
   logic signed       [4:0] sum;
   logic                    neg;
   logic              [3:0] mag;
   logic              [2:0] spd;
   logic              [3:0] q;
   logic              [6:0] rem7;
   logic              [2:0] rem;
   logic signed       [4:0] clicks;
   logic signed       [5:0] target;
   logic              [3:0] clamped;

   always_comb begin
      idx    = {ab_ff[1:0], sample.pin_a, sample.pin_b};
      step   = step_of(idx);
      sum    = {pend_ff[3], pend_ff} + {{3{step[1]}}, step};
      neg    = sum[4];
      mag    = neg ? 4'(-sum) : sum[3:0];
      spd    = (cfg.steps_per_detent == 3'd0) ? 3'd1 : cfg.steps_per_detent;
      q      = detent_div(mag, spd);
      rem7   = {3'b0, mag} - 7'(q) * {4'b0, spd};
      rem    = rem7[2:0];
      clicks = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      target = $signed({2'b00, level_ff}) + {clicks[4], clicks};
      // no whole detent leaves the level alone, even above a lowered limit
      if (q == 4'd0) begin
         clamped = level_ff;
      end else if (target > $signed({2'b00, cfg.max_level})) begin
         clamped = cfg.max_level;
      end else if (target < 6'sd0) begin
         clamped = 4'd0;
      end else begin
         clamped = target[3:0];
      end
   end

   always_comb begin
      ab_in    = ab_ff;
      pend_in  = pend_ff;
      level_in = level_ff;
      lvl_push = 1'b0;
      if (accept) begin
         ab_in    = idx;
         pend_in  = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
         level_in = clamped;
         lvl_push = (clamped != level_ff);
      end
   end

   assign lvl_value = clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         ab_ff    <= 4'd0;
         pend_ff  <= 4'sd0;
         level_ff <= LEVEL_RESET;
      end else begin
         ab_ff    <= ab_in;
         pend_ff  <= pend_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

[rtl/qlf_fifo.sv]
`default_nettype none

module qlf_fifo
   import qlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [3:0] push_level,
   output logic            full,
   input  wire logic       pop,
   output logic [3:0]      head_level,
   output logic            empty
);

   logic [3:0] mem_ff [4];
   logic [2:0] wr_ff, wr_in;
   logic [2:0] rd_ff, rd_in;

   assign empty      = (wr_ff == rd_ff);
   assign full       = (wr_ff[1:0] == rd_ff[1:0]) && (wr_ff[2] != rd_ff[2]);
   assign head_level = mem_ff[rd_ff[1:0]];

   always_comb begin
      wr_in = (push && !full) ? wr_ff + 3'd1 : wr_ff;
      rd_in = (pop && !empty) ? rd_ff + 3'd1 : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff[1:0]] <= push_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 3'd0;
         rd_ff <= 3'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

endmodule

`default_nettype wire

[rtl/qlf_back.sv]
`default_nettype none

module qlf_back
   import qlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       lvl_empty,
   input  wire logic [3:0] lvl_head,
   output logic            lvl_pop,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data
);

   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] lvl_ff, lvl_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;

   logic       advance;
   logic       have;
   logic [3:0] src_lvl;
   logic [2:0] src_cnt;

   always_comb begin
      advance  = !valid_ff || rsp_pop;
      have     = busy_ff || !lvl_empty;
      src_lvl  = busy_ff ? lvl_ff : lvl_head;
      src_cnt  = busy_ff ? cnt_ff : 3'd0;
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      lvl_pop  = 1'b0;
      if (advance) begin
         valid_in = have;
         if (have) begin
            data_in.frame_byte = frame_byte_of(src_lvl, src_cnt);
            data_in.last_byte  = (src_cnt == LAST_IDX);
            lvl_pop            = !busy_ff;
            lvl_in             = src_lvl;
            busy_in            = (src_cnt != LAST_IDX);
            cnt_in             = src_cnt + 3'd1;
         end
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/quadrature_level_framer_top.sv]
`default_nettype none

// quadrature wheel to brightness frame: each word pushed is one sample of the
// encoder pins a and b. the front end decodes the transition, gathers steps
// into whole detents (steps_per_detent at byte address 0, 0 counts as 1) and
// moves a level clamped to 0..max_level (address 4). it takes one sample per
// cycle while the level queue has room; each level change is queued (four
// deep) for the frame generator, which sends 0x55 0x12 level+2 0x0d 0x0a,
// one byte per word, one word per cycle while rsp_pop is high, last_byte set
// on the final one. a frame takes five words, so the generator can hold back
// level changes; full rises only when the level queue is full. the user must
// write registers only while the block is idle; the block does not check it.
module quadrature_level_framer_top
   import qlf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // sample channel
   input  wire logic        req_push,
   output logic             req_full,
   input  wire req_type     req_data,
   // frame byte channel
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       csr_wr;
   logic       accept;
   logic       lvl_push;
   logic [3:0] lvl_value;
   logic       lvl_full;
   logic       lvl_pop;
   logic [3:0] lvl_head;
   logic       lvl_empty;

   // register file, decoded on address bit 2
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_SPD: cfg_in.steps_per_detent = csr_pwdata[2:0];
            CSR_MAX: cfg_in.max_level        = csr_pwdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_SPD: csr_prdata = {29'b0, cfg_ff.steps_per_detent};
         CSR_MAX: csr_prdata = {28'b0, cfg_ff.max_level};
         default: csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_detent <= SPD_RESET;
         cfg_ff.max_level        <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a sample is taken whenever the level queue has room
   assign req_full = lvl_full;
   assign accept   = req_push && !lvl_full;

   qlf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .sample    (req_data),
      .lvl_push  (lvl_push),
      .lvl_value (lvl_value)
   );

   qlf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (lvl_push),
      .push_level (lvl_value),
      .full       (lvl_full),
      .pop        (lvl_pop),
      .head_level (lvl_head),
      .empty      (lvl_empty)
   );

   qlf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .lvl_empty (lvl_empty),
      .lvl_head  (lvl_head),
      .lvl_pop   (lvl_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
